// File: sv/swf_pkg.sv
// Shared types, codes and default sizes for the shadow register write filter.
package swf_pkg;

    localparam int CHIP_COUNT_DEF    = 2;
    localparam int REGS_PER_CHIP_DEF = 256;
    localparam int DELAY_BITS_DEF    = 32;

    localparam int OP_W        = 2;
    localparam int CHIP_W      = 1;
    localparam int ADDR_W      = 8;
    localparam int VALUE_W     = 8;
    localparam int DELAY_IN_W  = 32;
    localparam int OUT_DELAY_W = 32;

    typedef enum logic [OP_W-1:0] {
        OP_DELAY = 2'd0,
        OP_WRITE = 2'd1,
        OP_RMW   = 2'd2,
        OP_FLUSH = 2'd3
    } op_t;

    typedef enum logic {
        KIND_WRITE = 1'b0,
        KIND_DELAY = 1'b1
    } kind_t;

    // One shadow store word: written mark and last value sent to the chip.
    typedef struct packed {
        logic               written;
        logic [VALUE_W-1:0] value;
    } entry_t;

endpackage

// File: sv/swf_shadow_store.sv
// Shadow register store with registered read, write forwarding and clearing pass.
module swf_shadow_store #(
    parameter int DEPTH = swf_pkg::CHIP_COUNT_DEF * swf_pkg::REGS_PER_CHIP_DEF,
    parameter int IDX_W = $clog2(DEPTH)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 rd_en,
    input  logic [IDX_W-1:0]     rd_addr,
    output swf_pkg::entry_t      rd_entry,
    input  logic                 wr_en,
    input  logic [IDX_W-1:0]     wr_addr,
    input  swf_pkg::entry_t      wr_entry,
    output logic                 busy
);

    swf_pkg::entry_t mem [DEPTH];
    swf_pkg::entry_t mem_q_reg;
    swf_pkg::entry_t fwd_entry_reg;
    logic            fwd_hit_reg;
    logic            fwd_hit_next;
    logic            clear_reg;
    logic            clear_next;
    logic [IDX_W-1:0] clr_idx_reg;
    logic [IDX_W-1:0] clr_idx_next;
    logic            clr_last;

    assign clr_last = (clr_idx_reg == IDX_W'(DEPTH - 1));

    always_comb
    begin
        clear_next   = clear_reg;
        clr_idx_next = clr_idx_reg;
        if (clear_reg)
        begin
            clr_idx_next = clr_idx_reg + 1'b1;
            if (clr_last)
            begin
                clear_next = 1'b0;
            end
        end
    end

    // Catch a write landing on the address being read in the same cycle.
    always_comb
    begin
        fwd_hit_next = fwd_hit_reg;
        if (rd_en)
        begin
            fwd_hit_next = wr_en && (wr_addr == rd_addr);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_reg   <= 1'b1;
            clr_idx_reg <= '0;
            fwd_hit_reg <= 1'b0;
        end
        else
        begin
            clear_reg   <= clear_next;
            clr_idx_reg <= clr_idx_next;
            fwd_hit_reg <= fwd_hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clear_reg)
        begin
            mem[clr_idx_reg] <= '0;
        end
        else if (wr_en)
        begin
            mem[wr_addr] <= wr_entry;
        end
        if (rd_en)
        begin
            mem_q_reg     <= mem[rd_addr];
            fwd_entry_reg <= wr_entry;
        end
    end

    assign rd_entry = fwd_hit_reg ? fwd_entry_reg : mem_q_reg;
    assign busy     = clear_reg;

`ifndef SYNTH
    a_no_access_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clear_reg |-> (!rd_en && !wr_en))
        else $error("store accessed during clearing pass");

    a_clear_ends_at_last: assert property (@(posedge clk) disable iff (!rst_n)
        (clear_reg && !clr_last) |=> clear_reg)
        else $error("clearing pass ended early");

    a_clear_stays_done: assert property (@(posedge clk) disable iff (!rst_n)
        !clear_reg |=> !clear_reg)
        else $error("clearing pass restarted without reset");
`endif

endmodule

// File: sv/shadow_register_write_filter.sv
// Top level of the shadow register write filter: input stage, decision logic, result register.
//
//  channel  direction  handshake                   payload
//  item     in         item_valid / item_stall     op chip reg_addr value and_mask delay_in
//  result   out        result_valid / result_stall kind out_chip out_reg out_value out_delay
//
// One item per cycle while results flow; an item is decided in the cycle after its
// transfer and its result is registered when that stage advances. Store reads are
// registered and back-to-back writes to one register are forwarded inside the store.
// After reset a clearing pass sweeps CHIP_COUNT*REGS_PER_CHIP entries (512 by
// default) with item_stall held high. A stalled result holds the decision stage only
// when that stage has a result to emit; dropped writes and delay adds still advance.
module shadow_register_write_filter #(
    parameter int CHIP_COUNT    = swf_pkg::CHIP_COUNT_DEF,
    parameter int REGS_PER_CHIP = swf_pkg::REGS_PER_CHIP_DEF,
    parameter int DELAY_BITS    = swf_pkg::DELAY_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    output logic                              item_stall,
    input  logic [swf_pkg::OP_W-1:0]          op,
    input  logic [swf_pkg::CHIP_W-1:0]        chip,
    input  logic [swf_pkg::ADDR_W-1:0]        reg_addr,
    input  logic [swf_pkg::VALUE_W-1:0]       value,
    input  logic [swf_pkg::VALUE_W-1:0]       and_mask,
    input  logic [swf_pkg::DELAY_IN_W-1:0]    delay_in,
    output logic                              result_valid,
    input  logic                              result_stall,
    output logic                              kind,
    output logic [swf_pkg::CHIP_W-1:0]        out_chip,
    output logic [swf_pkg::ADDR_W-1:0]        out_reg,
    output logic [swf_pkg::VALUE_W-1:0]       out_value,
    output logic [swf_pkg::OUT_DELAY_W-1:0]   out_delay
);

    localparam int DEPTH = CHIP_COUNT * REGS_PER_CHIP;
    localparam int IDX_W = $clog2(DEPTH);
    // Wide enough for the pending delay and the 32-bit input, plus a carry.
    localparam int OW    = (DELAY_BITS > swf_pkg::DELAY_IN_W) ? DELAY_BITS
                                                              : swf_pkg::DELAY_IN_W;
    localparam int SUM_W = OW + 1;
    localparam logic [SUM_W-1:0] DELAY_MAX = SUM_W'({DELAY_BITS{1'b1}});
    localparam logic [OW-1:0]    OUT_MAX   = OW'({swf_pkg::OUT_DELAY_W{1'b1}});

    // ---------------------------------------------------------------
    // Input transfer and store address
    // ---------------------------------------------------------------
    logic             accept;
    logic             store_busy;
    logic [IDX_W-1:0] idx_in;
    logic             in_range;

    assign accept   = item_valid && !item_stall;
    assign idx_in   = IDX_W'(32'(chip) * 32'(REGS_PER_CHIP) + 32'(reg_addr));
    // Drop writes aimed past the configured chips or registers.
    assign in_range = (32'(chip) < 32'(CHIP_COUNT)) && (32'(reg_addr) < 32'(REGS_PER_CHIP));

    // ---------------------------------------------------------------
    // Decision stage registers
    // ---------------------------------------------------------------
    logic                              s1_valid_reg;
    logic                              s1_valid_next;
    logic [swf_pkg::OP_W-1:0]          s1_op_reg;
    logic [swf_pkg::CHIP_W-1:0]        s1_chip_reg;
    logic [swf_pkg::ADDR_W-1:0]        s1_addr_reg;
    logic [swf_pkg::VALUE_W-1:0]       s1_value_reg;
    logic [swf_pkg::VALUE_W-1:0]       s1_mask_reg;
    logic [swf_pkg::DELAY_IN_W-1:0]    s1_delay_reg;
    logic [IDX_W-1:0]                  s1_idx_reg;
    logic                              s1_in_range_reg;
    logic [DELAY_BITS-1:0]             pend_reg;
    logic [DELAY_BITS-1:0]             pend_next;

    // ---------------------------------------------------------------
    // Shadow store
    // ---------------------------------------------------------------
    swf_pkg::entry_t rd_entry;
    swf_pkg::entry_t wr_entry;
    logic            wr_en;

    swf_shadow_store #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (accept),
        .rd_addr  (idx_in),
        .rd_entry (rd_entry),
        .wr_en    (wr_en),
        .wr_addr  (s1_idx_reg),
        .wr_entry (wr_entry),
        .busy     (store_busy)
    );

    // ---------------------------------------------------------------
    // Decision logic
    // ---------------------------------------------------------------
    swf_pkg::op_t                    s1_op;
    logic [swf_pkg::VALUE_W-1:0]     new_value;
    logic                            is_write;
    logic                            is_flush;
    logic                            do_write;
    logic                            emit;
    logic                            s1_adv;
    logic [SUM_W-1:0]                delay_sum;
    logic [DELAY_BITS-1:0]           pend_sum;
    logic [OW-1:0]                   pend_wide;
    logic [swf_pkg::OUT_DELAY_W-1:0] delay_out;

    assign s1_op = swf_pkg::op_t'(s1_op_reg);

    always_comb
    begin
        new_value = s1_value_reg;
        is_write  = 1'b0;
        is_flush  = 1'b0;
        case (s1_op)
            swf_pkg::OP_DELAY:
            begin
                is_write = 1'b0;
            end
            swf_pkg::OP_WRITE:
            begin
                is_write = 1'b1;
            end
            swf_pkg::OP_RMW:
            begin
                is_write  = 1'b1;
                new_value = (rd_entry.value & s1_mask_reg) | s1_value_reg;
            end
            swf_pkg::OP_FLUSH:
            begin
                is_flush = 1'b1;
            end
            default:
            begin
                is_write = 1'b0;
            end
        endcase
    end

    // Drop a write that repeats the value already held by a written register.
    assign do_write = is_write && s1_in_range_reg
                      && !(rd_entry.written && (rd_entry.value == new_value));
    assign emit     = s1_valid_reg && (is_flush || do_write);

    // Advance unless a result waits on a full, stalled result register.
    assign s1_adv = s1_valid_reg && (!emit || !result_valid || !result_stall);

    assign wr_en    = s1_adv && do_write;
    assign wr_entry = '{written: 1'b1, value: new_value};

    // Saturating pending delay, then clamp to the output width.
    assign delay_sum = SUM_W'(pend_reg) + SUM_W'(s1_delay_reg);
    assign pend_sum  = (delay_sum > DELAY_MAX) ? '1 : delay_sum[DELAY_BITS-1:0];
    assign pend_wide = OW'(pend_sum);
    assign delay_out = (pend_wide > OUT_MAX) ? '1 : pend_wide[swf_pkg::OUT_DELAY_W-1:0];

    always_comb
    begin
        pend_next = pend_reg;
        if (s1_adv)
        begin
            pend_next = emit ? '0 : pend_sum;
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
    end

    // Hold off items during the clearing pass and while the stage is blocked.
    assign item_stall = store_busy || (s1_valid_reg && !s1_adv);

    // ---------------------------------------------------------------
    // Result register
    // ---------------------------------------------------------------
    logic                            res_valid_reg;
    logic                            res_valid_next;
    logic                            res_kind_reg;
    logic [swf_pkg::CHIP_W-1:0]      res_chip_reg;
    logic [swf_pkg::ADDR_W-1:0]      res_addr_reg;
    logic [swf_pkg::VALUE_W-1:0]     res_value_reg;
    logic [swf_pkg::OUT_DELAY_W-1:0] res_delay_reg;
    logic                            load_res;

    assign load_res = s1_adv && emit;

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (load_res)
        begin
            res_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            pend_reg      <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
            pend_reg      <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg       <= op;
            s1_chip_reg     <= chip;
            s1_addr_reg     <= reg_addr;
            s1_value_reg    <= value;
            s1_mask_reg     <= and_mask;
            s1_delay_reg    <= delay_in;
            s1_idx_reg      <= idx_in;
            s1_in_range_reg <= in_range;
        end
        if (load_res)
        begin
            res_kind_reg  <= is_flush ? swf_pkg::KIND_DELAY : swf_pkg::KIND_WRITE;
            res_chip_reg  <= is_flush ? '0 : s1_chip_reg;
            res_addr_reg  <= is_flush ? '0 : s1_addr_reg;
            res_value_reg <= is_flush ? '0 : new_value;
            res_delay_reg <= delay_out;
        end
    end

    assign result_valid = res_valid_reg;
    assign kind         = res_kind_reg;
    assign out_chip     = res_chip_reg;
    assign out_reg      = res_addr_reg;
    assign out_value    = res_value_reg;
    assign out_delay    = res_delay_reg;

`ifndef SYNTH
    a_emit_clears_pending: assert property (@(posedge clk) disable iff (!rst_n)
        load_res |=> (pend_reg == '0))
        else $error("pending delay not cleared after emitted result");

    a_block_only_on_stalled_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_adv) |-> (result_valid && result_stall && emit))
        else $error("decision stage blocked without a stalled result");

    a_delay_only_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (kind == swf_pkg::KIND_DELAY))
            |-> (out_chip == '0 && out_reg == '0 && out_value == '0))
        else $error("delay-only result carries write fields");

    a_no_item_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        store_busy |-> !s1_valid_reg)
        else $error("item in flight during clearing pass");
`endif

endmodule
